[design/signed_decimal_segment_encoder_macros.svh]
// ----------------------------------------------------------------------------
// Signed decimal segment encoder: assertion macros
// Shared implication forms, clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SIGNED_DECIMAL_SEGMENT_ENCODER_MACROS_SVH
`define SIGNED_DECIMAL_SEGMENT_ENCODER_MACROS_SVH

// same-cycle implication
`define SDSE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sdse check failed");

// next-cycle implication
`define SDSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sdse check failed");

`endif

[design/sdse_pkg.sv]
// ----------------------------------------------------------------------------
// sdse_pkg
// Types, codes and the digit table of the signed decimal segment encoder.
// ----------------------------------------------------------------------------
package sdse_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIGIT,
        ST_FINISH,
        ST_CLEAR,
        ST_SEG,
        ST_PULSE
    } t_state;

    typedef enum logic [1:0] {
        KIND_CLEAR   = 2'd0,
        KIND_SEGMENT = 2'd1,
        KIND_PULSE   = 2'd2
    } t_kind;

    localparam logic [7:0]  DASH_CODE  = 8'hF7;
    localparam logic [7:0]  POINT_MASK = 8'hFE;
    localparam logic [31:0] RECIP_10   = 32'hCCCC_CCCD;

    typedef struct packed {
        logic load;
        logic step;
        logic mark;
        logic finish;
        logic emit_next;
        logic seg_sel;
    } t_cmd;

    typedef struct packed {
        logic ovf;
        logic last_digit;
        logic emit_last;
    } t_status;

    function automatic logic [7:0] digit_code(input logic [3:0] d);
        logic [7:0] c;
        case (d)
            4'd0: c = 8'h09;
            4'd1: c = 8'hCF;
            4'd2: c = 8'h91;
            4'd3: c = 8'h85;
            4'd4: c = 8'h47;
            4'd5: c = 8'h25;
            4'd6: c = 8'h21;
            4'd7: c = 8'h8F;
            4'd8: c = 8'h01;
            4'd9: c = 8'h05;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[design/sdse_req_if.sv]
// ----------------------------------------------------------------------------
// sdse_req_if
// Request channel: signed value and display mode.
// ----------------------------------------------------------------------------
interface sdse_req_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               op;

    modport source (output valid, value, op, input ready);
    modport sink   (input valid, value, op, output ready);
endinterface

[design/sdse_rsp_if.sv]
// ----------------------------------------------------------------------------
// sdse_rsp_if
// Symbol channel: symbol kind, segment byte and end-of-run flag.
// ----------------------------------------------------------------------------
interface sdse_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] symbol_kind;
    logic [7:0] segment_byte;
    logic       last;

    modport source (output valid, symbol_kind, segment_byte, last, input ready);
    modport sink   (input valid, symbol_kind, segment_byte, last, output ready);
endinterface

[design/sdse_datapath.sv]
// ----------------------------------------------------------------------------
// sdse_datapath
// Magnitude register, divide-by-ten step and the position byte registers.
// ----------------------------------------------------------------------------
module sdse_datapath #(
    parameter int POSITIONS = 5
) (
    input  logic                i_clk,
    input  logic signed [31:0]  i_value,
    input  logic                i_op,
    input  sdse_pkg::t_cmd      i_cmd,
    output sdse_pkg::t_status   o_status,
    output logic [7:0]          o_segment_byte
);

    localparam int CW = $clog2(POSITIONS + 1);
    localparam int IW = $clog2(POSITIONS);

    logic [31:0]   r_mag;
    logic          r_neg;
    logic          r_dec;
    logic [CW-1:0] r_count;
    logic [7:0]    r_pos [POSITIONS];

    logic [63:0]   w_prod;
    logic [31:0]   w_quot;
    logic [31:0]   w_rem;
    logic [CW:0]   w_used;
    logic [CW-1:0] w_cnt_m1;
    logic [IW-1:0] w_wr_idx;
    logic [IW-1:0] w_rd_idx;

    // floor(mag / 10) via reciprocal, exact over 32 bits
    assign w_prod   = {32'd0, r_mag} * {32'd0, sdse_pkg::RECIP_10};
    assign w_quot   = {3'd0, w_prod[63:35]};
    assign w_rem    = r_mag - (w_quot << 3) - (w_quot << 1);
    assign w_used   = {1'b0, r_count} + {{CW{1'b0}}, r_neg};
    assign w_cnt_m1 = r_count - CW'(1);
    assign w_wr_idx = r_count[IW-1:0];
    assign w_rd_idx = w_cnt_m1[IW-1:0];

    assign o_status.ovf        = (w_used >= (CW+1)'(POSITIONS));
    assign o_status.last_digit = (w_quot == 32'd0) && !(r_dec && (r_count <= CW'(1)));
    assign o_status.emit_last  = (r_count == CW'(1));

    assign o_segment_byte = i_cmd.seg_sel ? r_pos[w_rd_idx] : 8'h00;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg   <= i_value[31];
            r_mag   <= i_value[31] ? (32'd0 - i_value) : i_value;
            r_dec   <= i_op;
            r_count <= '0;
            for (int i = 0; i < POSITIONS; i++) begin
                r_pos[i] <= 8'h00;
            end
        end else if (i_cmd.step) begin
            r_pos[w_wr_idx] <= sdse_pkg::digit_code(w_rem[3:0]);
            r_mag           <= w_quot;
            r_count         <= r_count + CW'(1);
        end else if (i_cmd.mark) begin
            r_pos[0] <= r_pos[0] & sdse_pkg::POINT_MASK;
        end else if (i_cmd.finish) begin
            // dash wins over the point when it lands on position 2
            if (r_dec && !(r_neg && (w_wr_idx == IW'(2)))) begin
                r_pos[2] <= r_pos[2] & sdse_pkg::POINT_MASK;
            end
            if (r_neg) begin
                r_pos[w_wr_idx] <= sdse_pkg::DASH_CODE;
                r_count         <= r_count + CW'(1);
            end
        end else if (i_cmd.emit_next) begin
            r_count <= r_count - CW'(1);
        end
    end

endmodule

[design/sdse_ctrl.sv]
// ----------------------------------------------------------------------------
// sdse_ctrl
// Sequencer: accept, digit steps, fixups, then clear / segments / pulse.
// ----------------------------------------------------------------------------
module sdse_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output logic [1:0]        o_kind,
    output logic              o_last,
    output sdse_pkg::t_cmd    o_cmd,
    input  sdse_pkg::t_status i_status
);

    sdse_pkg::t_state r_state;
    sdse_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdse_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_rsp_valid = 1'b0;
        o_kind      = sdse_pkg::KIND_CLEAR;
        o_last      = 1'b0;
        o_cmd       = '0;
        case (r_state)
            sdse_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = sdse_pkg::ST_DIGIT;
                end
            end
            sdse_pkg::ST_DIGIT: begin
                if (i_status.ovf) begin
                    o_cmd.mark = 1'b1;
                    n_state    = sdse_pkg::ST_FINISH;
                end else begin
                    o_cmd.step = 1'b1;
                    if (i_status.last_digit) begin
                        n_state = sdse_pkg::ST_FINISH;
                    end
                end
            end
            sdse_pkg::ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = sdse_pkg::ST_CLEAR;
            end
            sdse_pkg::ST_CLEAR: begin
                o_rsp_valid = 1'b1;
                if (i_rsp_ready) begin
                    n_state = sdse_pkg::ST_SEG;
                end
            end
            sdse_pkg::ST_SEG: begin
                o_rsp_valid   = 1'b1;
                o_kind        = sdse_pkg::KIND_SEGMENT;
                o_cmd.seg_sel = 1'b1;
                if (i_rsp_ready) begin
                    o_cmd.emit_next = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = sdse_pkg::ST_PULSE;
                    end
                end
            end
            sdse_pkg::ST_PULSE: begin
                o_rsp_valid = 1'b1;
                o_kind      = sdse_pkg::KIND_PULSE;
                o_last      = 1'b1;
                if (i_rsp_ready) begin
                    n_state = sdse_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sdse_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[design/signed_decimal_segment_encoder.sv]
// Sequence: an accepted request runs the digit loop, overflow mark included,
// then a finish step, then its symbol run opening with the clear frame.
// Requests are taken one at a time: ready is high only in idle, which is
// reached again once the closing pulse is taken; the sink may stall symbols.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle.
// ----------------------------------------------------------------------------
// signed_decimal_segment_encoder
// Signed value to seven-segment symbol run: clear frame, bytes, closing pulse.
// ----------------------------------------------------------------------------
module signed_decimal_segment_encoder #(
    parameter int POSITIONS = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdse_req_if.sink    i_req,
    sdse_rsp_if.source  o_rsp
);

    sdse_pkg::t_cmd    w_cmd;
    sdse_pkg::t_status w_status;
    logic [1:0]        w_kind;
    logic              w_last;
    logic              w_rsp_valid;
    logic              w_req_ready;
    logic [7:0]        w_seg;

    sdse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .o_rsp_valid (w_rsp_valid),
        .i_rsp_ready (o_rsp.ready),
        .o_kind      (w_kind),
        .o_last      (w_last),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    sdse_datapath #(
        .POSITIONS (POSITIONS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_value        (i_req.value),
        .i_op           (i_req.op),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_segment_byte (w_seg)
    );

    assign i_req.ready        = w_req_ready;
    assign o_rsp.valid        = w_rsp_valid;
    assign o_rsp.symbol_kind  = w_kind;
    assign o_rsp.segment_byte = w_seg;
    assign o_rsp.last         = w_last;

endmodule

[design/sdse_checker.sv]
// ----------------------------------------------------------------------------
// sdse_checker
// Port-level checks of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "signed_decimal_segment_encoder_macros.svh"

module sdse_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [1:0]  i_rsp_kind,
    input logic [7:0]  i_rsp_seg,
    input logic        i_rsp_last
);

    `SDSE_ASSERT_NOW(a_last_on_pulse, i_rsp_valid, i_rsp_last == (i_rsp_kind == sdse_pkg::KIND_PULSE))

    `SDSE_ASSERT_NOW(a_pulse_zero_byte, i_rsp_valid && (i_rsp_kind != sdse_pkg::KIND_SEGMENT), i_rsp_seg == 8'h00)

    `SDSE_ASSERT_NEXT(a_busy_after_request, i_req_valid && i_req_ready, !i_req_ready)

    `SDSE_ASSERT_NEXT(a_idle_after_last, i_rsp_valid && i_rsp_ready && i_rsp_last, !i_rsp_valid && i_req_ready)

    `SDSE_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_kind) && $stable(i_rsp_seg))

endmodule

bind signed_decimal_segment_encoder sdse_checker u_sdse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_kind  (o_rsp.symbol_kind),
    .i_rsp_seg   (o_rsp.segment_byte),
    .i_rsp_last  (o_rsp.last)
);

[dv/sdse_checker.sv]
// ----------------------------------------------------------------------------
// tb_sdse_checker
// Watches the request and symbol channels of the segment encoder. Each
// accepted request is turned into its expected symbol run: a clear frame, the
// segment bytes from the most significant position down, and a closing pulse.
// Every accepted symbol is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module tb_sdse_checker #(
    parameter int POSITIONS = 5
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sdse_req_if  i_req,
    sdse_rsp_if  i_rsp,
    output int   o_mismatches,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        sdse_pkg::t_kind kind;
        logic [7:0]      seg;
        logic            last;
    } t_symbol;

    localparam logic [7:0] SEG_OF_DIGIT [10] = '{
        8'h09, 8'hCF, 8'h91, 8'h85, 8'h47, 8'h25, 8'h21, 8'h8F, 8'h01, 8'h05
    };

    t_symbol expected_symbols [$];

    function automatic void predict_symbols(input logic signed [31:0] value, input logic op);
        logic [7:0]  shown [POSITIONS];
        logic        neg;
        logic [31:0] mag;
        int          used;
        bit          done;
        neg  = value[31];
        mag  = neg ? (~value + 32'd1) : value;
        used = 0;
        done = 0;
        foreach (shown[i]) shown[i] = 8'h00;
        while (!done) begin
            if (used + neg >= POSITIONS) begin
                // overflow: keep the low digits, mark position 0
                shown[0] &= sdse_pkg::POINT_MASK;
                done = 1;
            end else begin
                shown[used] = SEG_OF_DIGIT[mag % 10];
                mag  = mag / 10;
                used++;
                if (mag == 0 && !(op && used <= 2)) done = 1;
            end
        end
        if (op) shown[2] &= sdse_pkg::POINT_MASK;
        if (neg) begin
            shown[used] = sdse_pkg::DASH_CODE;
            used++;
        end
        expected_symbols.push_back('{sdse_pkg::KIND_CLEAR, 8'h00, 1'b0});
        for (int i = used - 1; i >= 0; i--) begin
            expected_symbols.push_back('{sdse_pkg::KIND_SEGMENT, shown[i], 1'b0});
        end
        expected_symbols.push_back('{sdse_pkg::KIND_PULSE, 8'h00, 1'b1});
    endfunction

    function automatic void note_mismatch(input string msg);
        o_mismatches++;
        if (o_mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    always @(posedge i_clk) begin : watch
        t_symbol want;
        if (!i_rst_n) begin
            expected_symbols.delete();
            o_mismatches = 0;
        end else begin
            if (i_req.valid && i_req.ready) predict_symbols(i_req.value, i_req.op);
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_symbols.size() == 0) begin
                    note_mismatch($sformatf("unexpected symbol kind=%0d seg=%02h last=%b",
                        i_rsp.symbol_kind, i_rsp.segment_byte, i_rsp.last));
                end else begin
                    want = expected_symbols.pop_front();
                    if (i_rsp.symbol_kind !== want.kind || i_rsp.segment_byte !== want.seg ||
                        i_rsp.last !== want.last) begin
                        note_mismatch($sformatf(
                            "expected kind=%0d seg=%02h last=%b, got kind=%0d seg=%02h last=%b",
                            want.kind, want.seg, want.last,
                            i_rsp.symbol_kind, i_rsp.segment_byte, i_rsp.last));
                    end
                end
            end
        end
        o_pending = expected_symbols.size();
    end

endmodule

[dv/tb_signed_decimal_segment_encoder.sv]
// ----------------------------------------------------------------------------
// tb_signed_decimal_segment_encoder
// Drives signed values in integer and two-decimal mode into the segment
// encoder: a directed set of edge cases, then random requests over four
// phases with varying sender idling and receiver stalls. The checker does the
// prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_signed_decimal_segment_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POSITIONS       = 5;
    localparam int RANDOM_REQUESTS = 200;
    localparam int PHASES          = 4;

    localparam int IDLE_PCT  [PHASES] = '{0, 74, 0, 31};
    localparam int STALL_PCT [PHASES] = '{0, 0, 74, 31};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   idle_pct  = 0;
    int   stall_pct = 0;
    int   mismatches;
    int   pending;

    sdse_req_if req_if ();
    sdse_rsp_if rsp_if ();

    signed_decimal_segment_encoder #(
        .POSITIONS (POSITIONS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    tb_sdse_checker #(
        .POSITIONS (POSITIONS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input logic signed [31:0] value, input logic op);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.value <= value;
        req_if.op    <= op;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        logic [31:0] mag;
        int          digits;
        int          span;
        case ($urandom_range(9))
            0: mag = $urandom();
            1: begin
                case ($urandom_range(5))
                    0: mag = 32'd0;
                    1: mag = 32'd99999;
                    2: mag = 32'd100000;
                    3: mag = 32'h7FFF_FFFF;
                    4: mag = 32'h8000_0000;
                    default: mag = 32'd9999;
                endcase
            end
            default: begin
                digits = $urandom_range(7, 1);
                span   = 10 ** digits;
                mag    = $urandom_range(span - 1, (digits == 1) ? 0 : span / 10);
            end
        endcase
        return $urandom_range(1) ? -mag : mag;
    endfunction

    initial begin
        req_if.valid = 1'b0;
        req_if.value = '0;
        req_if.op    = 1'b0;
        rsp_if.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: zero, digit edges, overflow with and without dash, extremes
        send_request(32'sd0, 1'b0);
        send_request(32'sd0, 1'b1);
        send_request(32'sd1, 1'b0);
        send_request(-32'sd1, 1'b0);
        send_request(32'sd9, 1'b0);
        send_request(32'sd10, 1'b0);
        send_request(32'sd12345, 1'b0);
        send_request(32'sd99999, 1'b0);
        send_request(32'sd100000, 1'b0);
        send_request(-32'sd9999, 1'b0);
        send_request(-32'sd10000, 1'b0);
        send_request(32'sh7FFF_FFFF, 1'b0);
        send_request(32'sh8000_0000, 1'b0);
        send_request(-32'sd2147483647, 1'b1);
        send_request(32'sd5, 1'b1);
        send_request(-32'sd5, 1'b1);
        send_request(32'sd123, 1'b1);
        send_request(-32'sd123, 1'b1);
        send_request(32'sd99999, 1'b1);
        send_request(32'sd100000, 1'b1);
        send_request(-32'sd9999, 1'b1);
        send_request(-32'sd10000, 1'b1);
        send_request(32'sh8000_0000, 1'b1);
        send_request(32'sh7FFF_FFFF, 1'b1);

        for (int p = 0; p < PHASES; p++) begin
            idle_pct  = IDLE_PCT[p];
            stall_pct = STALL_PCT[p];
            repeat (RANDOM_REQUESTS / PHASES) send_request(pick_value(), 1'($urandom_range(1)));
        end

        req_if.valid <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/sdse_pkg.sv
design/sdse_req_if.sv
design/sdse_rsp_if.sv
design/sdse_datapath.sv
design/sdse_ctrl.sv
design/signed_decimal_segment_encoder.sv
design/sdse_checker.sv
dv/sdse_checker.sv
dv/tb_signed_decimal_segment_encoder.sv
